@@ rtl/glpf_pkg.sv @@
// Shared types, constants and the pixel classifier for the grid line projection finder.
// Used by every module of the block and by its checker; depends on nothing else.

package glpf_pkg;

	// Field and register widths.
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned LINE_W    = 10;
	localparam int unsigned CFG_W     = 11;
	localparam int unsigned GAP_W     = 10;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned COLOUR_W  = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Default sizes of the column store and the row range.
	localparam int unsigned DEF_MAX_WIDTH  = 1024;
	localparam int unsigned DEF_MAX_HEIGHT = 1024;

	// Register values after reset.
	localparam logic             RST_PIXEL_MODE    = 1'b0;
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
	localparam logic [CFG_W-1:0] RST_ROW_THRESHOLD = 11'd160;
	localparam logic [CFG_W-1:0] RST_COL_THRESHOLD = 11'd120;
	localparam logic [GAP_W-1:0] RST_MIN_GAP       = 10'd5;

	// Colour rules. The dark rule compares the sum against three times the mean limit.
	localparam logic [9:0] DARK_SUM_LIMIT = 10'd450;
	localparam logic [7:0] CYAN_BG_MIN    = 8'd150;
	localparam logic [7:0] CYAN_R_MAX     = 8'd100;
	localparam logic [8:0] DOM_R_MARGIN   = 9'd50;
	localparam logic [8:0] DOM_G_MARGIN   = 9'd30;
	localparam logic [7:0] LIGHT_B_MIN    = 8'd200;
	localparam logic [7:0] LIGHT_G_MIN    = 8'd180;
	localparam logic [7:0] LIGHT_R_MAX    = 8'd150;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_MODE    = 3'd0,
		REG_IMAGE_WIDTH   = 3'd1,
		REG_IMAGE_HEIGHT  = 3'd2,
		REG_ROW_THRESHOLD = 3'd3,
		REG_COL_THRESHOLD = 3'd4,
		REG_MIN_GAP       = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_SCAN  = 1'b1
	} opcode_t;

	// Input word.
	typedef struct packed {
		opcode_t             opcode;
		logic [COLOUR_W-1:0] red;
		logic [COLOUR_W-1:0] green;
		logic [COLOUR_W-1:0] blue;
	} item_t;

	// Output word.
	typedef struct packed {
		logic [LINE_W-1:0] line_position;
		logic              is_vertical;
	} result_t;

	// Operation handed from the front end to the column store stage.
	typedef struct packed {
		logic              valid;
		logic              is_scan;
		logic              scan_active;
		logic              scan_last;
		logic              hit;
		logic              row_hit;
		logic [LINE_W-1:0] row_pos;
	} op_t;

	// True when the pixel counts towards a line under the selected mode.
	function automatic logic is_line_pixel(input logic mode, input logic [COLOUR_W-1:0] r,
		input logic [COLOUR_W-1:0] g, input logic [COLOUR_W-1:0] b);
		logic [9:0] sum;
		logic [8:0] r_ref;
		logic [8:0] g_ref;
		logic       cyan;
		logic       dominant;
		logic       light;
		sum      = 10'(r) + 10'(g) + 10'(b);
		r_ref    = 9'(r) + DOM_R_MARGIN;
		g_ref    = 9'(g) + DOM_G_MARGIN;
		cyan     = (b > CYAN_BG_MIN) && (g > CYAN_BG_MIN) && (r < CYAN_R_MAX);
		dominant = (9'(b) > r_ref) && (9'(b) > g_ref);
		light    = (b > LIGHT_B_MIN) && (g > LIGHT_G_MIN) && (r < LIGHT_R_MAX);
		return mode ? (sum < DARK_SUM_LIMIT) : (cyan | dominant | light);
	endfunction

endpackage

@@ rtl/grid_line_projection_finder.sv @@
// Top level of the grid line projection finder: configuration registers, size clamping,
// the input stall and the wiring of glpf_front, glpf_colmem and glpf_outq. Uses glpf_pkg.

// The block takes one word per clock while item_stall is low, pixels in raster order or column
// scans, and gives a line word through the op_s1 register and a two-word output queue.
// Each word reads its column counter once and writes it at most once, on one read and one
// write port of the counter memory, so the sustained rate is one word per cycle when nothing
// stalls. After reset a clearing pass zeroes all MAX_WIDTH column counters (1024 by default),
// and item_stall stays high throughout; configuration writes are taken at any time.

module grid_line_projection_finder #(
	parameter int unsigned MAX_WIDTH  = glpf_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = glpf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [glpf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glpf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  glpf_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output glpf_pkg::result_t               result
);
	import glpf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = CW + 1;
	localparam int unsigned HW = $clog2(MAX_HEIGHT) + 1;

	logic             pixel_mode_q;
	logic [CFG_W-1:0] image_width_q;
	logic [CFG_W-1:0] image_height_q;
	logic [CFG_W-1:0] row_threshold_q;
	logic [CFG_W-1:0] col_threshold_q;
	logic [GAP_W-1:0] min_gap_q;

	logic [WW-1:0]    width_eff;
	logic [HW-1:0]    height_eff;
	logic             accept;
	logic [CW-1:0]    rd_addr;
	logic [CW-1:0]    addr_s1;
	op_t              op_s1;
	logic             clr_busy;
	logic             res_valid;
	result_t          res;
	logic [1:0]       level;
	logic [2:0]       occupancy;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q    <= RST_PIXEL_MODE;
			image_width_q   <= RST_IMAGE_WIDTH;
			image_height_q  <= RST_IMAGE_HEIGHT;
			row_threshold_q <= RST_ROW_THRESHOLD;
			col_threshold_q <= RST_COL_THRESHOLD;
			min_gap_q       <= RST_MIN_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_MODE:    pixel_mode_q    <= cfg_data[0];
				REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				REG_ROW_THRESHOLD: row_threshold_q <= cfg_data;
				REG_COL_THRESHOLD: col_threshold_q <= cfg_data;
				REG_MIN_GAP:       min_gap_q       <= cfg_data[GAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sizes in use: zero acts as one, and sizes are held to MAX_WIDTH and MAX_HEIGHT.
	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			height_eff = HW'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			height_eff = HW'(MAX_HEIGHT);
		end else begin
			height_eff = HW'(image_height_q);
		end
	end

	// A word is held back only when the queue could overflow or the clearing pass runs.
	always_comb begin
		occupancy  = 3'(level) - 3'(result_valid && !result_stall) + 3'(op_s1.valid);
		item_stall = clr_busy || (occupancy >= 3'd2);
		accept     = item_valid && !item_stall;
	end

	glpf_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.item          (item),
		.pixel_mode    (pixel_mode_q),
		.width_eff     (width_eff),
		.height_eff    (height_eff),
		.row_threshold (row_threshold_q),
		.min_gap       (min_gap_q),
		.rd_addr       (rd_addr),
		.op_s1         (op_s1),
		.addr_s1       (addr_s1)
	);

	glpf_colmem #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_colmem (
		.clk           (clk),
		.arst_n        (arst_n),
		.rd_en         (accept),
		.rd_addr       (rd_addr),
		.op_s1         (op_s1),
		.addr_s1       (addr_s1),
		.col_threshold (col_threshold_q),
		.min_gap       (min_gap_q),
		.clr_busy      (clr_busy),
		.res_valid     (res_valid),
		.res           (res)
	);

	glpf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_word (res),
		.stall     (result_stall),
		.valid     (result_valid),
		.word      (result),
		.level     (level)
	);

endmodule

@@ rtl/glpf_front.sv @@
// Front end: classifies pixels, keeps the raster and scan cursors and decides row lines.
// Uses glpf_pkg; feeds the read address and the registered operation to glpf_colmem.

module glpf_front #(
	parameter int unsigned MAX_WIDTH  = glpf_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = glpf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  glpf_pkg::item_t                       item,
	input  logic                                  pixel_mode,
	input  logic [$clog2(MAX_WIDTH):0]            width_eff,
	input  logic [$clog2(MAX_HEIGHT):0]           height_eff,
	input  logic [glpf_pkg::CFG_W-1:0]            row_threshold,
	input  logic [glpf_pkg::GAP_W-1:0]            min_gap,
	output logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
	output glpf_pkg::op_t                         op_s1,
	output logic [$clog2(MAX_WIDTH)-1:0]          addr_s1
);
	import glpf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);

	logic [CW-1:0]      column_cursor_q;
	logic [CW-1:0]      scan_pointer_q;
	logic [RW-1:0]      row_cursor_q;
	logic [RW-1:0]      last_row_line_q;
	logic               row_line_seen_q;
	logic [COUNT_W-1:0] row_count_q;

	logic               is_scan;
	logic               hit;
	logic [CW-1:0]      col;
	logic [RW-1:0]      row;
	logic               row_end;
	logic               frame_end;
	logic [COUNT_W-1:0] count_next;
	logic [RW-1:0]      row_dist;
	logic               row_far;
	logic               row_hit;
	logic               scan_active;
	logic               scan_last;

	// Classification and position of the current word.
	always_comb begin
		is_scan     = (item.opcode == OP_SCAN);
		hit         = !is_scan && is_line_pixel(pixel_mode, item.red, item.green, item.blue);
		col         = (32'(column_cursor_q) < 32'(width_eff)) ?
			column_cursor_q : CW'(width_eff - 1'b1);
		row         = (32'(row_cursor_q) < 32'(height_eff)) ?
			row_cursor_q : RW'(height_eff - 1'b1);
		row_end     = (32'(col) + 32'd1) >= 32'(width_eff);
		frame_end   = (32'(row) + 32'd1) >= 32'(height_eff);
		count_next  = (hit && (row_count_q != COUNT_MAX)) ? row_count_q + 1'b1 : row_count_q;
		row_dist    = (row >= last_row_line_q) ? row - last_row_line_q : last_row_line_q - row;
		row_far     = !row_line_seen_q || (32'(row_dist) > 32'(min_gap));
		row_hit     = row_end && (count_next > row_threshold) && row_far;
		scan_active = 32'(scan_pointer_q) < 32'(width_eff);
		scan_last   = (32'(scan_pointer_q) + 32'd1) >= 32'(width_eff);
		rd_addr     = is_scan ? scan_pointer_q : col;
	end

	// Cursors, the row counter and the row line history.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_cursor_q <= '0;
			scan_pointer_q  <= '0;
			row_cursor_q    <= '0;
			last_row_line_q <= '0;
			row_line_seen_q <= 1'b0;
			row_count_q     <= '0;
		end else if (accept) begin
			if (is_scan) begin
				scan_pointer_q <= (scan_active && !scan_last) ? scan_pointer_q + 1'b1 : '0;
			end else if (row_end) begin
				row_count_q     <= '0;
				column_cursor_q <= '0;
				if (row_hit) begin
					last_row_line_q <= row;
					row_line_seen_q <= 1'b1;
				end
				if (frame_end) begin
					row_cursor_q    <= '0;
					row_line_seen_q <= 1'b0;
				end else begin
					row_cursor_q <= row + 1'b1;
				end
			end else begin
				row_count_q     <= count_next;
				column_cursor_q <= col + 1'b1;
			end
		end
	end

	// Operation register towards the column store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.valid <= accept;
			if (accept) begin
				op_s1.is_scan     <= is_scan;
				op_s1.scan_active <= scan_active;
				op_s1.scan_last   <= scan_last;
				op_s1.hit         <= hit;
				op_s1.row_hit     <= row_hit && !is_scan;
				op_s1.row_pos     <= LINE_W'(row);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= rd_addr;
		end
	end

endmodule

@@ rtl/glpf_colmem.sv @@
// Column counter store: the counter memory, its clearing pass after reset, the
// read-modify-write with forwarding and the vertical line decision. Uses glpf_pkg.

module glpf_colmem #(
	parameter int unsigned MAX_WIDTH = glpf_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0]      rd_addr,
	input  glpf_pkg::op_t                     op_s1,
	input  logic [$clog2(MAX_WIDTH)-1:0]      addr_s1,
	input  logic [glpf_pkg::CFG_W-1:0]        col_threshold,
	input  logic [glpf_pkg::GAP_W-1:0]        min_gap,
	output logic                              clr_busy,
	output logic                              res_valid,
	output glpf_pkg::result_t                 res
);
	import glpf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);

	logic [COUNT_W-1:0] mem [MAX_WIDTH];
	logic [COUNT_W-1:0] rd_data_s1;

	logic               clr_busy_q;
	logic [CW-1:0]      clr_addr_q;
	logic               fwd_valid_q;
	logic [CW-1:0]      fwd_addr_q;
	logic [COUNT_W-1:0] fwd_data_q;
	logic [CW-1:0]      last_col_line_q;
	logic               col_line_seen_q;

	logic               op_wr;
	logic [COUNT_W-1:0] cur;
	logic [COUNT_W-1:0] new_count;
	logic               wr_en;
	logic [CW-1:0]      wr_addr;
	logic [COUNT_W-1:0] wr_data;
	logic [CW-1:0]      col_dist;
	logic               col_far;
	logic               col_emit;

	assign clr_busy = clr_busy_q;

	// Counter read for this operation, taking the word that the previous cycle's operation
	// wrote when it hit the same column.
	always_comb begin
		cur       = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data_s1;
		op_wr     = op_s1.valid && (op_s1.is_scan ? op_s1.scan_active : op_s1.hit);
		new_count = op_s1.is_scan ? '0 :
			((cur != COUNT_MAX) ? cur + 1'b1 : cur);
		wr_en     = clr_busy_q || op_wr;
		wr_addr   = clr_busy_q ? clr_addr_q : addr_s1;
		wr_data   = clr_busy_q ? '0 : new_count;
	end

	// Vertical line decision on a scan.
	always_comb begin
		col_dist  = (addr_s1 >= last_col_line_q) ?
			addr_s1 - last_col_line_q : last_col_line_q - addr_s1;
		col_far   = !col_line_seen_q || (32'(col_dist) > 32'(min_gap));
		col_emit  = op_s1.valid && op_s1.is_scan && op_s1.scan_active &&
			(cur > col_threshold) && col_far;
		res_valid = op_s1.valid && (op_s1.is_scan ? col_emit : op_s1.row_hit);
		res.line_position = op_s1.is_scan ? LINE_W'(addr_s1) : op_s1.row_pos;
		res.is_vertical   = op_s1.is_scan;
	end

	// Counter memory with one write and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Forwarding of the last write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= op_wr;
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s1;
		fwd_data_q <= new_count;
	end

	// Clearing pass over every counter after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == CW'(MAX_WIDTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	// Column line history; the end of a scan pass forgets it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_line_q <= '0;
			col_line_seen_q <= 1'b0;
		end else if (op_s1.valid && op_s1.is_scan) begin
			if (col_emit) begin
				last_col_line_q <= addr_s1;
				col_line_seen_q <= 1'b1;
			end
			if (!op_s1.scan_active || op_s1.scan_last) begin
				col_line_seen_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/glpf_outq.sv @@
// Two-word output queue that parts the result channel from the pipeline.
// Uses glpf_pkg for the result word.

module glpf_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  glpf_pkg::result_t push_word,
	input  logic              stall,
	output logic              valid,
	output glpf_pkg::result_t word,
	output logic [1:0]        level
);
	import glpf_pkg::*;

	result_t    slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign valid = (count_q != 2'd0);
	assign word  = slot_q[rd_ptr_q];
	assign pop   = valid && !stall;
	assign level = count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

@@ rtl/glpf_checker.sv @@
// Port-level checks for the grid line projection finder, bound to its top level.
// Uses glpf_pkg for the result word.

module glpf_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input glpf_pkg::result_t result
);
	import glpf_pkg::*;

	// A stalled result word stays and holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed or vanished");

	// A rising result_valid must follow an accepted word, through the operation register and the output queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result appeared without an accepted word");

	// The clearing pass holds the input off right after reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> item_stall)
		else $error("word taken before the counter clearing pass");

endmodule

bind grid_line_projection_finder glpf_checker u_glpf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

@@ bench/tb_top.sv @@
// Self-checking bench for grid_line_projection_finder: directed words, then random frames
// and column scans, all checked against a line predictor held in the bench itself.
// Depends on glpf_pkg and the grid_line_projection_finder RTL only.

module tb_top;
	import glpf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned RANDOM_WORDS  = 1050;
	localparam int unsigned COLUMN_PIXELS = 300;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;

	// Register copies held by the predictor.
	logic             mode_dark  = RST_PIXEL_MODE;
	logic [CFG_W-1:0] width_reg  = RST_IMAGE_WIDTH;
	logic [CFG_W-1:0] height_reg = RST_IMAGE_HEIGHT;
	logic [CFG_W-1:0] row_limit  = RST_ROW_THRESHOLD;
	logic [CFG_W-1:0] col_limit  = RST_COL_THRESHOLD;
	logic [GAP_W-1:0] gap_reg    = RST_MIN_GAP;

	// Projection state of the predictor.
	int unsigned pix_col, pix_row, row_hits, scan_col;
	int unsigned col_hits [DEF_MAX_WIDTH];
	int unsigned last_row_pos, last_col_pos;
	bit          row_pos_valid, col_pos_valid;

	item_t       words_to_send [$];
	result_t     expected_lines [$];

	int unsigned words_queued, words_sent, row_lines_ok, col_lines_ok, settings_used;
	int unsigned mismatches, cycles;
	int unsigned send_gap, recv_wait, hold_left;
	int unsigned holds_requested, holds_served;
	bit          send_quiet, recv_quiet;

	grid_line_projection_finder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Zero acts as one, anything above the store size acts as the store size.
	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned top);
		if (v == '0) return 1;
		return (v > top) ? top : int'(v);
	endfunction

	function automatic bit counts_as_line(input logic dark, input int unsigned r,
		input int unsigned g, input int unsigned b);
		if (dark) return ((r + g + b) / 3) < 150;
		if (b > 150 && g > 150 && r < 100) return 1'b1;
		if (b > r + 50 && b > g + 30) return 1'b1;
		return b > 200 && g > 180 && r < 150;
	endfunction

	// Per-word line prediction: row lines at row ends, column lines from scans.
	task automatic project_word(input item_t w);
		int unsigned iw, ih, col, row, sp, delta;
		result_t     line;
		iw = clamp_dim(width_reg, DEF_MAX_WIDTH);
		ih = clamp_dim(height_reg, DEF_MAX_HEIGHT);
		if (w.opcode == OP_PIXEL) begin
			col = (pix_col < iw) ? pix_col : iw - 1;
			if (counts_as_line(mode_dark, w.red, w.green, w.blue)) begin
				if (row_hits < COUNT_MAX) row_hits++;
				if (col_hits[col] < COUNT_MAX) col_hits[col]++;
			end
			if (col + 1 >= iw) begin
				row   = (pix_row < ih) ? pix_row : ih - 1;
				delta = (row >= last_row_pos) ? row - last_row_pos : last_row_pos - row;
				if (row_hits > row_limit && (!row_pos_valid || delta > gap_reg)) begin
					line.line_position = LINE_W'(row);
					line.is_vertical   = 1'b0;
					expected_lines.push_back(line);
					last_row_pos  = row;
					row_pos_valid = 1'b1;
				end
				row_hits = 0;
				pix_col  = 0;
				if (row + 1 >= ih) begin
					pix_row       = 0;
					row_pos_valid = 1'b0;
				end else begin
					pix_row = row + 1;
				end
			end else begin
				pix_col = col + 1;
			end
		end else begin
			sp = scan_col;
			if (sp >= iw) begin
				// Pointer left beyond a shrunken width: restart the scan, no line.
				scan_col      = 0;
				col_pos_valid = 1'b0;
			end else begin
				delta = (sp >= last_col_pos) ? sp - last_col_pos : last_col_pos - sp;
				if (col_hits[sp] > col_limit && (!col_pos_valid || delta > gap_reg)) begin
					line.line_position = LINE_W'(sp);
					line.is_vertical   = 1'b1;
					expected_lines.push_back(line);
					last_col_pos  = sp;
					col_pos_valid = 1'b1;
				end
				col_hits[sp] = 0;
				if (sp + 1 >= iw) begin
					scan_col      = 0;
					col_pos_valid = 1'b0;
				end else begin
					scan_col = sp + 1;
				end
			end
		end
	endtask

	task automatic check_line(input result_t got);
		result_t want;
		if (expected_lines.size() == 0) begin
			$error("line word with none expected: position %0d vertical %0d",
				got.line_position, got.is_vertical);
			mismatches++;
		end else begin
			want = expected_lines.pop_front();
			if (got.line_position !== want.line_position) begin
				$error("line_position: expected %0d, got %0d", want.line_position,
					got.line_position);
				mismatches++;
			end
			if (got.is_vertical !== want.is_vertical) begin
				$error("is_vertical: expected %0d, got %0d", want.is_vertical, got.is_vertical);
				mismatches++;
			end
			if (want.is_vertical) col_lines_ok++;
			else row_lines_ok++;
		end
	endtask

	// Wait length for the next word, with occasional stretches of no idling at all.
	function automatic int unsigned next_wait(inout bit quiet);
		if ($urandom_range(0, 31) == 0) quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 7);
	endfunction

	// Sender: offers queued words, holds a stalled word, predicts each accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (item_valid && !item_stall) begin
				project_word(item);
				words_sent++;
			end
			if (!(item_valid && item_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					item_valid <= 1'b0;
				end else if (words_to_send.size() > 0) begin
					item       <= words_to_send.pop_front();
					item_valid <= 1'b1;
					send_gap = next_wait(send_quiet);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted line word, stalls at random and on request for long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_wait = 0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_line(result);
				recv_wait = next_wait(recv_quiet);
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= (recv_wait > 0);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL grid_line_projection_finder");
			$finish;
		end
	end

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PIXEL_MODE:    mode_dark  = val[0];
			REG_IMAGE_WIDTH:   width_reg  = val;
			REG_IMAGE_HEIGHT:  height_reg = val;
			REG_ROW_THRESHOLD: row_limit  = val;
			REG_COL_THRESHOLD: col_limit  = val;
			REG_MIN_GAP:       gap_reg    = val[GAP_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic mode, input logic [CFG_W-1:0] w,
		input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] rt, input logic [CFG_W-1:0] ct,
		input logic [GAP_W-1:0] gap);
		write_reg(REG_PIXEL_MODE, CFG_W'(mode));
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_ROW_THRESHOLD, rt);
		write_reg(REG_COL_THRESHOLD, ct);
		write_reg(REG_MIN_GAP, CFG_W'(gap));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Block is idle once nothing is pending or expected for a run of quiet cycles.
	task automatic wait_idle();
		int unsigned quiet_run;
		quiet_run = 0;
		while (quiet_run < SETTLE_CYCLES) begin
			@(posedge clk);
			if (words_to_send.size() != 0 || item_valid || expected_lines.size() != 0)
				quiet_run = 0;
			else
				quiet_run++;
		end
	endtask

	task automatic send_word(input item_t w);
		words_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic send_pixel(input int unsigned r, input int unsigned g, input int unsigned b);
		item_t w;
		w.opcode = OP_PIXEL;
		w.red    = COLOUR_W'(r);
		w.green  = COLOUR_W'(g);
		w.blue   = COLOUR_W'(b);
		send_word(w);
	endtask

	function automatic item_t scan_word();
		item_t w;
		w.opcode = OP_SCAN;
		w.red    = COLOUR_W'($urandom);
		w.green  = COLOUR_W'($urandom);
		w.blue   = COLOUR_W'($urandom);
		return w;
	endfunction

	function automatic item_t noise_word();
		item_t w;
		w = scan_word();
		w.opcode = $urandom_range(0, 1) ? OP_SCAN : OP_PIXEL;
		return w;
	endfunction

	// Colour that is (or is not) a line pixel in the given mode, with some plain noise.
	function automatic item_t paint(input logic dark, input bit on_line);
		item_t       w;
		int unsigned r, g, b;
		w = noise_word();
		w.opcode = OP_PIXEL;
		if ($urandom_range(0, 11) == 0) return w;
		if (dark && on_line) begin
			r = $urandom_range(0, 149);
			g = $urandom_range(0, 149);
			b = $urandom_range(0, 149);
		end else if (dark) begin
			r = $urandom_range(150, 255);
			g = $urandom_range(150, 255);
			b = $urandom_range(150, 255);
		end else if (!on_line) begin
			r = $urandom_range(150, 255);
			g = $urandom_range(0, 255);
			b = $urandom_range(0, r);
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					r = $urandom_range(0, 99);
					g = $urandom_range(151, 255);
					b = $urandom_range(151, 255);
				end
				1: begin
					b = $urandom_range(51, 255);
					r = $urandom_range(0, b - 51);
					g = $urandom_range(0, b - 31);
				end
				default: begin
					r = $urandom_range(0, 149);
					g = $urandom_range(181, 255);
					b = $urandom_range(201, 255);
				end
			endcase
		end
		w.red   = COLOUR_W'(r);
		w.green = COLOUR_W'(g);
		w.blue  = COLOUR_W'(b);
		return w;
	endfunction

	// A frame of grid-like rows and columns followed by a column scan, sometimes cut short.
	task automatic queue_frame();
		int unsigned iw, ih, rows, cut, n, r, c;
		bit          row_on;
		bit          col_on [];
		iw   = clamp_dim(width_reg, DEF_MAX_WIDTH);
		ih   = clamp_dim(height_reg, DEF_MAX_HEIGHT);
		rows = (ih > 12) ? $urandom_range(1, 12) : ih;
		cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, iw * rows - 1) : iw * rows;
		col_on = new[iw];
		foreach (col_on[k]) col_on[k] = ($urandom_range(0, 3) == 0);
		n = 0;
		for (r = 0; r < rows; r++) begin
			row_on = ($urandom_range(0, 2) == 0);
			for (c = 0; c < iw; c++) begin
				if (n < cut) send_word(paint(mode_dark, row_on || col_on[c]));
				n++;
			end
		end
		case ($urandom_range(0, 5))
			0:       n = $urandom_range(0, iw);
			1:       n = iw + $urandom_range(1, 3);
			default: n = iw;
		endcase
		repeat (n) send_word(scan_word());
	endtask

	task automatic random_setting();
		logic             mode;
		logic [CFG_W-1:0] w, h, rt, ct;
		logic [GAP_W-1:0] gap;
		mode = 1'($urandom_range(0, 1));
		w    = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom_range(1, 16));
		case ($urandom_range(0, 11))
			0:       h = '0;
			1:       h = '1;
			default: h = CFG_W'($urandom_range(1, 10));
		endcase
		rt = ($urandom_range(0, 15) == 0) ? '1 : CFG_W'($urandom_range(0, w));
		ct = ($urandom_range(0, 15) == 0) ? '1 : CFG_W'($urandom_range(0, 2 * h + 2));
		case ($urandom_range(0, 9))
			0:       gap = '1;
			1:       gap = GAP_W'($urandom_range(0, 1023));
			default: gap = GAP_W'($urandom_range(0, 3));
		endcase
		set_config(mode, w, h, rt, ct, gap);
	endtask

	// Stimulus sequence.
	initial begin
		int unsigned random_start;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Colour rule edges in blue mode, a full small frame, its scan and a wrapped scan.
		set_config(1'b0, 11'd4, 11'd2, 11'd1, 11'd0, 10'd0);
		send_pixel(0, 0, 0);
		send_pixel(0, 151, 151);
		send_pixel(99, 151, 151);
		send_pixel(100, 151, 151);
		send_pixel(255, 255, 255);
		send_pixel(0, 0, 255);
		send_pixel(149, 181, 201);
		send_pixel(255, 0, 0);
		repeat (5) send_word(scan_word());
		// Dominant and light-blue edges; leaves the cursors inside the second row.
		send_pixel(0, 30, 81);
		send_pixel(50, 30, 100);
		send_pixel(0, 50, 80);
		send_pixel(150, 181, 201);
		send_pixel(149, 181, 200);
		send_pixel(255, 255, 255);
		send_pixel(0, 0, 0);
		wait_idle();

		// Shrunk sizes end row and frame at once; dark-mean edge; scan beyond the width.
		set_config(1'b1, 11'd1, 11'd1, 11'd0, 11'd0, 10'd1023);
		send_pixel(150, 150, 149);
		send_pixel(150, 150, 150);
		send_pixel(0, 0, 0);
		send_pixel(255, 255, 255);
		repeat (2) send_word(scan_word());
		wait_idle();

		// Oversized registers clamp to the store size; all-ones thresholds and gap.
		set_config(1'b1, '1, '1, '1, '1, '1);
		repeat (64) send_word(paint(1'b1, 1'($urandom_range(0, 1))));
		repeat (8) send_word(scan_word());
		wait_idle();

		// One-pixel frames: every dark pixel is a row line, column 0 builds a tall count.
		// The receiver holds off for a long stretch meanwhile so the input stalls.
		set_config(1'b1, '0, '0, '0, 11'd298, '0);
		repeat (COLUMN_PIXELS) send_pixel($urandom_range(0, 149), $urandom_range(0, 149),
			$urandom_range(0, 149));
		repeat (2) send_word(scan_word());
		holds_requested++;
		wait_idle();

		// Random settings with mostly well-formed frames and some noise.
		random_start = words_queued;
		while (words_queued - random_start < RANDOM_WORDS) begin
			random_setting();
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 6) == 0)
					repeat ($urandom_range(4, 24)) send_word(noise_word());
				else
					queue_frame();
			end
			wait_idle();
		end

		$display("Sent %0d words under %0d register settings; matched %0d row lines and %0d",
			words_sent, settings_used, row_lines_ok, col_lines_ok);
		$display("column lines, including one-pixel frames, clamped sizes and a long hold-off.");
		if (mismatches == 0) begin
			$display("PASS grid_line_projection_finder");
		end else begin
			$display("FAIL grid_line_projection_finder");
		end
		$finish;
	end

endmodule
